[rtl/lfm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfm_pkg: shared types and constants
// Beat formats, sizing of the kept-value store, and the controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
package lfm_pkg;

	localparam int MAX_KEEP   = 256;
	localparam int ADDR_W     = $clog2(MAX_KEEP);
	localparam int CNT_W      = $clog2(MAX_KEEP + 1);
	localparam int KEEP_W     = 9;
	localparam int TEMP_W     = 16;
	localparam int CMP_W      = (KEEP_W > CNT_W) ? KEEP_W : CNT_W;
	localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(230);

	typedef struct packed {
		logic signed [TEMP_W-1:0] pixel_temp;
		logic                     last_pixel;
	} pix_in_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] ambient_temp;
		logic                     frame_too_short;
	} amb_out_t;

	// Read address selection for memory port A.
	typedef enum logic [1:0] {
		RA_TOP  = 2'd0,
		RA_PREV = 2'd1,
		RA_MED  = 2'd2
	} ra_sel_t;

	typedef struct packed {
		logic    load;
		ra_sel_t rd_sel;
		logic    wr_v;
		logic    wr_shift;
		logic    out_load;
	} lfm_cmd_t;

	typedef struct packed {
		logic room;
		logic lt;
		logic pos_zero;
		logic last;
		logic out_busy;
	} lfm_status_t;

endpackage

[rtl/lfm_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfm_ctrl: sequencing controller
// Steps each pixel through the full-list check, the insertion shift loop and,
// on the last pixel of a frame, the median read and result hand-off.
// ----------------------------------------------------------------------------
module lfm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  lfm_pkg::lfm_status_t status,
	output lfm_pkg::lfm_cmd_t    cmd
);
	import lfm_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE      = 6'b000001,
		ST_FULL      = 6'b000010,
		ST_SHIFT_RD  = 6'b000100,
		ST_SHIFT_CMP = 6'b001000,
		ST_CHECK     = 6'b010000,
		ST_MED       = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.rd_sel   = RA_PREV;
		in_stall     = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load   = 1'b1;
					cmd.rd_sel = RA_TOP;
					state_d    = status.room ? ST_SHIFT_RD : ST_FULL;
				end
			end
			ST_FULL: begin
				// A full list only takes a value strictly below its largest entry.
				state_d = status.lt ? ST_SHIFT_RD : ST_CHECK;
			end
			ST_SHIFT_RD: begin
				if (status.pos_zero) begin
					cmd.wr_v = 1'b1;
					state_d  = ST_CHECK;
				end else begin
					cmd.rd_sel = RA_PREV;
					state_d    = ST_SHIFT_CMP;
				end
			end
			ST_SHIFT_CMP: begin
				if (status.lt) begin
					cmd.wr_shift = 1'b1;
					state_d      = ST_SHIFT_RD;
				end else begin
					cmd.wr_v = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.last) begin
					cmd.rd_sel = RA_MED;
					state_d    = ST_MED;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_MED: begin
				// Keep the middle entries on the read ports while the result waits.
				cmd.rd_sel = RA_MED;
				if (!status.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[rtl/lfm_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfm_datapath: kept-value store and arithmetic
// Holds the sorted memory, fill count, insertion pointer, keep_count register
// and the output register, and forms the median of the two middle entries.
// ----------------------------------------------------------------------------
module lfm_datapath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lfm_pkg::lfm_cmd_t       cmd,
	output lfm_pkg::lfm_status_t    status,
	input  lfm_pkg::pix_in_t        in_data,
	input  logic                    cfg_wr_en,
	input  logic [lfm_pkg::KEEP_W-1:0] cfg_wr_data,
	output logic                    out_valid,
	input  logic                    out_stall,
	output lfm_pkg::amb_out_t       out_data
);
	import lfm_pkg::*;

	logic signed [TEMP_W-1:0] mem [MAX_KEEP];

	logic [KEEP_W-1:0]        keep_q;
	logic [CNT_W-1:0]         held_q;
	logic [ADDR_W-1:0]        pos_q;
	logic signed [TEMP_W-1:0] v_q;
	logic                     last_q;
	logic signed [TEMP_W-1:0] rd_a_q, rd_b_q;
	logic                     out_valid_q;
	amb_out_t                 out_q;

	logic [CNT_W-1:0]         k_eff;
	logic [CNT_W-1:0]         held_sat;
	logic                     room;
	logic [ADDR_W-1:0]        addr_a, addr_b, addr_mid;
	logic                     mem_we;
	logic [ADDR_W-1:0]        waddr;
	logic signed [TEMP_W-1:0] wdata;
	logic signed [TEMP_W:0]   mid_sum;

	// Zero acts as one; anything above capacity acts as the capacity.
	always_comb begin
		if (keep_q == '0) begin
			k_eff = CNT_W'(1);
		end else if (CMP_W'(keep_q) > CMP_W'(MAX_KEEP)) begin
			k_eff = CNT_W'(MAX_KEEP);
		end else begin
			k_eff = CNT_W'(keep_q);
		end
	end

	assign held_sat = (held_q > k_eff) ? k_eff : held_q;
	assign room     = held_sat < k_eff;
	assign addr_mid = ADDR_W'(held_q >> 1);

	always_comb begin
		case (cmd.rd_sel)
			RA_TOP:  addr_a = ADDR_W'(k_eff - CNT_W'(1));
			RA_PREV: addr_a = pos_q - ADDR_W'(1);
			RA_MED:  addr_a = held_q[0] ? addr_mid : addr_mid - ADDR_W'(1);
			default: addr_a = pos_q - ADDR_W'(1);
		endcase
	end

	assign addr_b = addr_mid;
	assign mem_we = cmd.wr_v | cmd.wr_shift;
	assign waddr  = pos_q;
	assign wdata  = cmd.wr_shift ? rd_a_q : v_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		rd_a_q <= mem[addr_a];
		rd_b_q <= mem[addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= KEEP_RESET;
			held_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				keep_q <= cfg_wr_data;
			end
			if (cmd.load) begin
				held_q <= room ? held_sat + CNT_W'(1) : held_sat;
			end else if (cmd.out_load) begin
				held_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v_q    <= in_data.pixel_temp;
			last_q <= in_data.last_pixel;
			pos_q  <= room ? ADDR_W'(held_sat) : ADDR_W'(k_eff - CNT_W'(1));
		end else if (cmd.wr_shift) begin
			pos_q <= pos_q - ADDR_W'(1);
		end
	end

	// For an odd count both ports read the middle entry, so the mean is exact.
	assign mid_sum = {rd_a_q[TEMP_W-1], rd_a_q} + {rd_b_q[TEMP_W-1], rd_b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.ambient_temp    <= mid_sum[TEMP_W:1];
			out_q.frame_too_short <= held_q < k_eff;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign status.room     = room;
	assign status.lt       = v_q < rd_a_q;
	assign status.pos_zero = pos_q == '0;
	assign status.last     = last_q;
	assign status.out_busy = out_valid_q & out_stall;

`ifndef SYNTH
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && out_stall))
		else $error("result loaded over a beat not yet taken");

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(held_q) <= CMP_W'(MAX_KEEP))
		else $error("fill count above capacity");

	a_held_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> held_q == '0)
		else $error("fill count not cleared after frame");

	a_shift_pos: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_shift |-> pos_q != '0)
		else $error("shift below the bottom of the list");
`endif

endmodule

[rtl/lowest_fraction_median_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lowest_fraction_median_unit: median of the coldest pixels of a frame
// Keeps the keep_count smallest pixel temperatures in a sorted memory and
// returns their median on the last pixel of each frame.
// ----------------------------------------------------------------------------
// One pixel is handled at a time; in_stall is low only while the unit waits
// for a pixel. A pixel that is kept is inserted by walking the single sorted
// memory one read-compare-write step per kept entry that it moves up, after
// a compare with the largest entry when the list is already full. A pixel
// that a full list does not take is dropped after that compare; the last
// pixel of a frame then reads the median and waits while an earlier result
// beat is still stalled.
// keep_count may be written only while the unit is idle.
module lowest_fraction_median_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  lfm_pkg::pix_in_t           in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output lfm_pkg::amb_out_t          out_data,
	input  logic                       cfg_wr_en,
	input  logic [lfm_pkg::KEEP_W-1:0] cfg_wr_data
);
	import lfm_pkg::*;

	lfm_cmd_t    cmd;
	lfm_status_t status;

	lfm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	lfm_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.in_data     (in_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule

[test/tb_lowest_fraction_median_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lowest_fraction_median_unit: self-checking bench for the coldest-pixel median
// Streams thermal frames through the unit under changing keep_count settings.
// Every accepted pixel updates a local sorted list of the coldest values.
// Each result beat is checked against the predicted median and short flag.
// ----------------------------------------------------------------------------
module tb_lowest_fraction_median_unit;

	import lfm_pkg::*;

	localparam int SETTLE_CYCLES  = 2 * MAX_KEEP + 64;
	localparam int RANDOM_TARGET  = 1920;
	localparam int SEND_IDLE[4]   = '{0, 87, 0, 25};
	localparam int RECV_STALL[4]  = '{0, 0, 87, 25};

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             in_valid    = 1'b0;
	logic             in_stall;
	pix_in_t          in_data     = '0;
	logic             out_valid;
	logic             out_stall   = 1'b0;
	amb_out_t         out_data;
	logic             cfg_wr_en   = 1'b0;
	logic [KEEP_W-1:0] cfg_wr_data = '0;

	// Pixels waiting to be driven, and predicted result beats in order.
	pix_in_t  pix_q[$];
	amb_out_t ambient_q[$];

	// Local copy of the unit's state.
	logic signed [TEMP_W-1:0] cold_list[MAX_KEEP];
	int                       held_n   = 0;
	logic [KEEP_W-1:0]        keep_reg = KEEP_RESET;

	int pix_queued     = 0;
	int pix_accepted   = 0;
	int frames_checked = 0;
	int short_frames   = 0;
	int keep_writes    = 0;
	int fail_count     = 0;
	int phase_n        = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	lowest_fraction_median_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #2 clk = ~clk;

	// Applies one accepted pixel to the coldest-value list and, on the last
	// pixel of a frame, queues the expected median beat.
	task automatic track_pixel(input pix_in_t px);
		int       k;
		int       pos;
		int       n;
		int       sum;
		amb_out_t res;
		k = (keep_reg == 0) ? 1 : ((keep_reg > MAX_KEEP) ? MAX_KEEP : int'(keep_reg));
		// A keep count lowered mid-frame cuts the list to its coldest entries.
		if (held_n > k)
			held_n = k;
		if (held_n < k) begin
			pos = held_n;
			held_n++;
		end else if (px.pixel_temp < cold_list[k-1]) begin
			pos = k - 1;
		end else begin
			pos = -1;
		end
		if (pos >= 0) begin
			// Strict compare keeps a new value behind equal kept values.
			while (pos > 0 && px.pixel_temp < cold_list[pos-1]) begin
				cold_list[pos] = cold_list[pos-1];
				pos--;
			end
			cold_list[pos] = px.pixel_temp;
		end
		if (px.last_pixel) begin
			n = held_n;
			if (n % 2 == 0) begin
				sum = int'(cold_list[n/2-1]) + int'(cold_list[n/2]);
				res.ambient_temp = TEMP_W'(sum >>> 1);
			end else begin
				res.ambient_temp = cold_list[n/2];
			end
			res.frame_too_short = (n < k);
			held_n = 0;
			ambient_q.push_back(res);
		end
	endtask

	task automatic push_pix(input int temp, input bit last);
		pix_in_t px;
		px.pixel_temp = TEMP_W'(temp);
		px.last_pixel = last;
		pix_q.push_back(px);
		pix_queued++;
	endtask

	// Only called while the unit is idle.
	task automatic set_keep(input logic [KEEP_W-1:0] v);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		keep_reg = v;
		keep_writes++;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Waits for every pixel and result beat, lets a pixel still in the
	// insertion walk finish, then moves on to the next idling mix.
	task automatic finish_phase();
		while (pix_accepted != pix_queued || ambient_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		phase_n++;
		send_idle_pct  = SEND_IDLE[phase_n % 4];
		recv_stall_pct = RECV_STALL[phase_n % 4];
	endtask

	function automatic logic signed [TEMP_W-1:0] pick_temp(input int base);
		case ($urandom_range(7))
			0:       return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
			1, 2:    return TEMP_W'($urandom);
			default: return TEMP_W'(base + int'($urandom_range(12)));
		endcase
	endfunction

	// Pixel driver: a stalled beat is held until it is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				track_pixel(in_data);
				pix_accepted++;
			end
			if (!(in_valid && in_stall)) begin
				if (pix_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_data  <= pix_q.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver stall.
	always @(posedge clk) begin : result_check
		amb_out_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (ambient_q.size() == 0) begin
					$error("result beat with no frame pending: ambient_temp %0d",
						out_data.ambient_temp);
					fail_count++;
				end else begin
					want = ambient_q.pop_front();
					frames_checked++;
					if (want.frame_too_short)
						short_frames++;
					if (out_data.ambient_temp !== want.ambient_temp) begin
						$error("ambient_temp: expected %0d, got %0d",
							want.ambient_temp, out_data.ambient_temp);
						fail_count++;
					end
					if (out_data.frame_too_short !== want.frame_too_short) begin
						$error("frame_too_short: expected %0d, got %0d",
							want.frame_too_short, out_data.frame_too_short);
						fail_count++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	initial begin
		int sel;
		int len;
		int kv;
		int base;
		bit cut;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset keep count with a frame far too short; both extremes.
		push_pix(32767, 0);
		push_pix(-32768, 0);
		push_pix(0, 1);
		finish_phase();

		// A keep count of zero behaves as one.
		set_keep(0);
		push_pix(5, 0);
		push_pix(-7, 0);
		push_pix(100, 1);
		finish_phase();

		// Even counts: overflow of the pair sum and flooring of negatives.
		set_keep(2);
		push_pix(32767, 0);
		push_pix(32767, 1);
		push_pix(-32768, 0);
		push_pix(-32767, 1);
		push_pix(-3, 0);
		push_pix(0, 0);
		push_pix(10, 1);
		finish_phase();

		// Ties with the largest kept value are not taken.
		set_keep(3);
		push_pix(5, 0);
		push_pix(5, 0);
		push_pix(5, 0);
		push_pix(5, 0);
		push_pix(4, 1);
		finish_phase();

		// Keep count lowered in the middle of a frame.
		set_keep(4);
		push_pix(10, 0);
		push_pix(20, 0);
		push_pix(30, 0);
		push_pix(40, 0);
		finish_phase();
		set_keep(2);
		push_pix(5, 1);
		finish_phase();

		// Keep counts above the store size saturate.
		set_keep(511);
		push_pix(-32768, 0);
		push_pix(32767, 1);
		finish_phase();
		set_keep(256);
		push_pix(1234, 1);
		finish_phase();

		// Random frames; mostly small keep counts sized from the frame.
		while (pix_queued < RANDOM_TARGET) begin
			sel = $urandom_range(99);
			if (sel < 2) begin
				kv  = $urandom_range(1) ? MAX_KEEP : $urandom_range(511, MAX_KEEP + 1);
				len = $urandom_range(300, MAX_KEEP);
			end else if (sel < 12) begin
				kv  = $urandom_range(40, 2);
				len = $urandom_range(kv - 1, 1);
			end else if (sel < 16) begin
				kv  = 0;
				len = $urandom_range(8, 1);
			end else begin
				len = $urandom_range(80, 2);
				kv  = len * 3 / 10;
			end
			if ($urandom_range(9) != 0)
				set_keep(KEEP_W'(kv));
			base = int'($urandom_range(64000)) - 32000;
			cut  = ($urandom_range(99) < 8);
			for (int i = 0; i < len; i++)
				push_pix(pick_temp(base), (i == len - 1) && !cut);
			finish_phase();
		end

		if (ambient_q.size() != 0) begin
			$error("%0d expected result beats never arrived", ambient_q.size());
			fail_count++;
		end
		$display("Covered %0d pixels in %0d checked frames, %0d of them short.",
			pix_accepted, frames_checked, short_frames);
		$display("Used %0d keep_count writes over %0d phases of idle and stall mixes.",
			keep_writes, phase_n);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#30_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
